// ----- hw/rtl/elx_pkg.sv -----
// Expression lexer: shared types and constants.
// Character codes, byte classes, queue entry, scan modes and result beat.
// No dependencies.
package elx_pkg;

	// result kinds beyond the eight operator codes (0..7)
	localparam logic [3:0] K_FN      = 4'd8;
	localparam logic [3:0] K_IDENT   = 4'd9;
	localparam logic [3:0] K_LITERAL = 4'd10;
	localparam logic [3:0] K_EOF     = 4'd11;
	localparam logic [3:0] K_ERROR   = 4'd12;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_POINT  = ".";
	localparam logic [7:0] CH_F      = "f";
	localparam logic [7:0] CH_N      = "n";
	localparam logic [7:0] CH_0      = "0";
	localparam logic [7:0] CH_9      = "9";
	localparam logic [7:0] CH_LA     = "a";
	localparam logic [7:0] CH_LZ     = "z";
	localparam logic [7:0] CH_UA     = "A";
	localparam logic [7:0] CH_UZ     = "Z";

	localparam logic [4:0] FRAC_MAX = 5'd31;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef enum logic [2:0] {
		CL_EOF,
		CL_SPACE,
		CL_OP,
		CL_ALPHA,
		CL_DIGIT,
		CL_POINT,
		CL_OTHER
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		cls_t       cls;
		logic [2:0] op_kind;
		logic       start_emits;  // handled from idle, this byte gives a result
	} entry_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_WORD,
		MD_INT,
		MD_FRAC,
		MD_DRAIN
	} mode_t;

	typedef enum logic {
		BK_RUN,
		BK_FLUSH
	} bk_state_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  char_value;
		logic        ident_end;
		logic [31:0] mantissa;
		logic [4:0]  frac_digits;
		logic        saturated;
		logic        last;
	} result_t;

endpackage

// ----- hw/rtl/elx_if.sv -----
// Expression lexer: valid/ready channel interfaces.
// Byte input channel and token output channel. No dependencies.
interface elx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface elx_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [7:0]  char_value;
	logic        ident_end;
	logic [31:0] mantissa;
	logic [4:0]  frac_digits;
	logic        saturated;
	logic        last;
	modport source (output valid, output kind, output char_value, output ident_end,
		output mantissa, output frac_digits, output saturated, output last, input ready);
	modport sink (input valid, input kind, input char_value, input ident_end,
		input mantissa, input frac_digits, input saturated, input last, output ready);
endinterface

// ----- hw/rtl/expression_lexer_unit.sv -----
// Expression lexer top level: byte stream in, token beats out.
// Depends on elx_pkg, elx_if, elx_front and elx_back.
//
// Usage
//   text   : one source byte per beat (valid/ready); byte 0 ends the input.
//   tokens : one result per beat; last marks the final result of a byte.
//   Front end classifies each byte into a two-entry queue; back end runs
//   the scan mode, buffers words and accumulates literals.
// Path: a taken byte enters the queue; its result is registered from the
//   queue head into the output register. Identifier characters first pass
//   the flush state, then follow one per cycle while tokens is ready.
// Throughput: one byte per cycle while words and literals build up or
//   whitespace is skipped. A byte that closes a literal is rerun from idle
//   after the literal is emitted; one that closes an identifier is rerun
//   after the flush state has fed out the word one character per beat.
// Stalls: the output register holds its beat while tokens.ready is low, and
//   the back end holds any new result; the queue keeps taking bytes until it
//   is full, then text.ready drops.
// Reset: arst_n clears the queue, the scan mode and the output valid; the
//   queue reads empty, so text.ready is already high when arst_n releases.
//   No clearing pass is needed.
module expression_lexer_unit #(
	parameter int WORD_CAP = 32
) (
	input logic       clk,
	input logic       arst_n,
	elx_in_if.sink    text,
	elx_out_if.source tokens
);
	import elx_pkg::*;

	entry_t head;
	logic   head_valid;
	logic   pop;

	elx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back end owns mode, word buffer and output register
	elx_back #(
		.WORD_CAP (WORD_CAP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tokens     (tokens)
	);

endmodule

// ----- hw/rtl/elx_front.sv -----
// Expression lexer front end: byte classifier and two-entry queue.
// Depends on elx_pkg and elx_in_if.
module elx_front (
	input  logic            clk,
	input  logic            arst_n,
	elx_in_if.sink          text,
	output logic            head_valid,
	output elx_pkg::entry_t head,
	input  logic            pop
);
	import elx_pkg::*;

	entry_t             cls_entry;
	logic               is_op;
	logic [2:0]         op_kind;
	entry_t             entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_PTR_W:0]   count_q;
	logic               push;

	always_comb begin
		is_op   = 1'b1;
		op_kind = 3'd0;
		unique case (text.ch)
			CH_PLUS:   op_kind = 3'd0;
			CH_MINUS:  op_kind = 3'd1;
			CH_STAR:   op_kind = 3'd2;
			CH_SLASH:  op_kind = 3'd3;
			CH_LPAREN: op_kind = 3'd4;
			CH_RPAREN: op_kind = 3'd5;
			CH_LBRACE: op_kind = 3'd6;
			CH_RBRACE: op_kind = 3'd7;
			default:   is_op = 1'b0;
		endcase
	end

	always_comb begin
		cls_entry.ch      = text.ch;
		cls_entry.op_kind = op_kind;
		priority if (text.ch == CH_NUL) begin
			cls_entry.cls = CL_EOF;
		end else if (text.ch == CH_SPACE || (text.ch >= CH_TAB && text.ch <= CH_CR)) begin
			cls_entry.cls = CL_SPACE;
		end else if (is_op) begin
			cls_entry.cls = CL_OP;
		end else if ((text.ch >= CH_LA && text.ch <= CH_LZ)
				|| (text.ch >= CH_UA && text.ch <= CH_UZ)) begin
			cls_entry.cls = CL_ALPHA;
		end else if (text.ch >= CH_0 && text.ch <= CH_9) begin
			cls_entry.cls = CL_DIGIT;
		end else if (text.ch == CH_POINT) begin
			cls_entry.cls = CL_POINT;
		end else begin
			cls_entry.cls = CL_OTHER;
		end
		cls_entry.start_emits = (cls_entry.cls == CL_EOF) || (cls_entry.cls == CL_OP)
			|| (cls_entry.cls == CL_POINT) || (cls_entry.cls == CL_OTHER);
	end

	assign text.ready = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
	assign push       = text.valid && text.ready;
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= cls_entry;
	end

endmodule

// ----- hw/rtl/elx_back.sv -----
// Expression lexer back end: scan-mode sequencer, word buffer, literal
// accumulator and output register. Depends on elx_pkg and elx_out_if.
module elx_back #(
	parameter int WORD_CAP = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  elx_pkg::entry_t head,
	output logic            pop,
	elx_out_if.source       tokens
);
	import elx_pkg::*;

	localparam int DEPTH = WORD_CAP - 1;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W = $clog2(WORD_CAP);

	bk_state_t         state_q, state_d;
	mode_t             mode_q, mode_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [31:0]       num_q, num_d;
	logic [4:0]        frac_q, frac_d;
	logic              ovf_q, ovf_d;
	logic [7:0]        word_q [DEPTH];
	logic              buf_we;
	logic [IDX_W-1:0]  buf_wa;
	logic              out_valid_q;
	result_t           out_q;
	result_t           res;
	logic              emit;
	logic              out_free;
	logic              word_full;
	logic              is_fn;
	logic              flush_end;
	logic [35:0]       acc_wide;
	logic [35:0]       acc_sum;

	assign out_free  = !out_valid_q || tokens.ready;
	assign word_full = (len_q >= LEN_W'(DEPTH));
	assign is_fn     = (len_q == LEN_W'(2)) && (word_q[0] == CH_F) && (word_q[1] == CH_N);
	assign flush_end = (LEN_W'(idx_q) == len_q - LEN_W'(1));
	assign acc_wide  = {4'b0, num_q};
	assign acc_sum   = (acc_wide << 3) + (acc_wide << 1) + 36'(head.ch[3:0]);

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		len_d   = len_q;
		idx_d   = idx_q;
		num_d   = num_q;
		frac_d  = frac_q;
		ovf_d   = ovf_q;
		pop     = 1'b0;
		emit    = 1'b0;
		res     = '0;
		buf_we  = 1'b0;
		buf_wa  = len_q[IDX_W-1:0];

		unique case (state_q)
			BK_FLUSH: begin
				// one identifier character per beat
				if (out_free) begin
					emit           = 1'b1;
					res.kind       = K_IDENT;
					res.char_value = word_q[idx_q];
					res.ident_end  = flush_end;
					res.last       = flush_end && !head.start_emits;
					if (flush_end) begin
						state_d = BK_RUN;
						mode_d  = MD_IDLE;
						len_d   = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			BK_RUN: begin
				if (head_valid) begin
					unique case (mode_q)
						MD_DRAIN: begin
							pop = 1'b1;
							if (head.cls == CL_EOF) mode_d = MD_IDLE;
						end
						MD_WORD: begin
							if (head.cls == CL_ALPHA || head.cls == CL_DIGIT) begin
								if (word_full) begin
									if (out_free) begin
										emit           = 1'b1;
										res.kind       = K_ERROR;
										res.char_value = head.ch;
										res.last       = 1'b1;
										len_d          = '0;
										mode_d         = MD_DRAIN;
										pop            = 1'b1;
									end
								end else begin
									buf_we = 1'b1;
									len_d  = len_q + 1'b1;
									pop    = 1'b1;
								end
							end else if (is_fn) begin
								if (out_free) begin
									emit     = 1'b1;
									res.kind = K_FN;
									res.last = !head.start_emits;
									len_d    = '0;
									mode_d   = MD_IDLE;
								end
							end else begin
								idx_d   = '0;
								state_d = BK_FLUSH;
							end
						end
						MD_INT, MD_FRAC: begin
							if (head.cls == CL_DIGIT) begin
								pop = 1'b1;
								if (|acc_sum[35:32]) begin
									num_d = '1;
									ovf_d = 1'b1;
								end else begin
									num_d = acc_sum[31:0];
								end
								if (mode_q == MD_FRAC) begin
									if (frac_q == FRAC_MAX) ovf_d = 1'b1;
									else frac_d = frac_q + 1'b1;
								end
							end else if (head.cls == CL_POINT && mode_q == MD_INT) begin
								pop    = 1'b1;
								mode_d = MD_FRAC;
							end else if (out_free) begin
								// literal ends; the byte is rerun from idle
								emit            = 1'b1;
								res.kind        = K_LITERAL;
								res.mantissa    = num_q;
								res.frac_digits = frac_q;
								res.saturated   = ovf_q;
								res.last        = !head.start_emits;
								num_d           = '0;
								frac_d          = '0;
								ovf_d           = 1'b0;
								mode_d          = MD_IDLE;
							end
						end
						default: begin
							unique case (head.cls)
								CL_SPACE: pop = 1'b1;
								CL_ALPHA: begin
									buf_we = 1'b1;
									buf_wa = '0;
									len_d  = LEN_W'(1);
									mode_d = MD_WORD;
									pop    = 1'b1;
								end
								CL_DIGIT: begin
									num_d  = {28'b0, head.ch[3:0]};
									frac_d = '0;
									ovf_d  = 1'b0;
									mode_d = MD_INT;
									pop    = 1'b1;
								end
								CL_EOF: begin
									if (out_free) begin
										emit     = 1'b1;
										res.kind = K_EOF;
										res.last = 1'b1;
										pop      = 1'b1;
									end
								end
								CL_OP: begin
									if (out_free) begin
										emit           = 1'b1;
										res.kind       = {1'b0, head.op_kind};
										res.char_value = head.ch;
										res.last       = 1'b1;
										pop            = 1'b1;
									end
								end
								default: begin
									if (out_free) begin
										emit           = 1'b1;
										res.kind       = K_ERROR;
										res.char_value = head.ch;
										res.last       = 1'b1;
										mode_d         = MD_DRAIN;
										pop            = 1'b1;
									end
								end
							endcase
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			mode_q      <= MD_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			num_q       <= '0;
			frac_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			num_q   <= num_d;
			frac_q  <= frac_d;
			ovf_q   <= ovf_d;
			if (emit) out_valid_q <= 1'b1;
			else if (tokens.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= res;
		if (buf_we) word_q[buf_wa] <= head.ch;
	end

	assign tokens.valid       = out_valid_q;
	assign tokens.kind        = out_q.kind;
	assign tokens.char_value  = out_q.char_value;
	assign tokens.ident_end   = out_q.ident_end;
	assign tokens.mantissa    = out_q.mantissa;
	assign tokens.frac_digits = out_q.frac_digits;
	assign tokens.saturated   = out_q.saturated;
	assign tokens.last        = out_q.last;

endmodule

// ----- hw/rtl/elx_checker.sv -----
// Expression lexer port checker and its bind to the top level.
// Depends on elx_pkg and expression_lexer_unit.
module elx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  kind,
	input logic [7:0]  char_value,
	input logic        ident_end,
	input logic [31:0] mantissa,
	input logic [4:0]  frac_digits,
	input logic        saturated,
	input logic        last
);
	import elx_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_value)
			&& $stable(mantissa) && $stable(last))
		else $error("token beat changed while stalled");

	a_lit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != K_LITERAL |-> mantissa == '0 && frac_digits == '0 && !saturated)
		else $error("literal fields set on non-literal token");

	a_ident_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ident_end |-> kind == K_IDENT)
		else $error("ident_end on non-identifier token");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_EOF || kind == K_ERROR) |-> last)
		else $error("end or error token not marked last");

endmodule

bind expression_lexer_unit elx_checker u_elx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.kind        (tokens.kind),
	.char_value  (tokens.char_value),
	.ident_end   (tokens.ident_end),
	.mantissa    (tokens.mantissa),
	.frac_digits (tokens.frac_digits),
	.saturated   (tokens.saturated),
	.last        (tokens.last)
);

// ----- test/elx_token_check_pkg.sv -----
// Token scoreboard for the expression lexer testbench: predicts the token
// beats that each accepted source byte causes and checks them in order.
// Depends on elx_pkg.
package elx_token_check_pkg;
	import elx_pkg::*;

	// operator kinds; elx_pkg names only the kinds above these
	localparam logic [3:0] K_PLUS   = 4'd0;
	localparam logic [3:0] K_MINUS  = 4'd1;
	localparam logic [3:0] K_STAR   = 4'd2;
	localparam logic [3:0] K_SLASH  = 4'd3;
	localparam logic [3:0] K_LPAREN = 4'd4;
	localparam logic [3:0] K_RPAREN = 4'd5;
	localparam logic [3:0] K_LBRACE = 4'd6;
	localparam logic [3:0] K_RBRACE = 4'd7;

	class token_scoreboard #(int WORD_CAP = 32);
		mode_t       mode;
		logic [7:0]  word_buf [WORD_CAP-1];
		int          word_len;
		logic [31:0] num_value;
		logic [4:0]  frac_count;
		logic        num_ovf;
		result_t     pending_tokens [$];
		result_t     byte_tokens [$];
		int          failures;
		int          tokens_checked;
		int          saturated_literals;
		int          kind_seen [16];

		function new();
			mode = MD_IDLE;
			word_len = 0;
			num_value = '0;
			frac_count = '0;
			num_ovf = 1'b0;
			failures = 0;
			tokens_checked = 0;
			saturated_literals = 0;
			foreach (kind_seen[i])
				kind_seen[i] = 0;
		endfunction

		static function bit is_digit(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		static function bit is_alpha(logic [7:0] c);
			return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
		endfunction

		static function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		// K_ERROR stands for "not an operator"
		static function logic [3:0] op_kind(logic [7:0] c);
			case (c)
				CH_PLUS:   return K_PLUS;
				CH_MINUS:  return K_MINUS;
				CH_STAR:   return K_STAR;
				CH_SLASH:  return K_SLASH;
				CH_LPAREN: return K_LPAREN;
				CH_RPAREN: return K_RPAREN;
				CH_LBRACE: return K_LBRACE;
				CH_RBRACE: return K_RBRACE;
				default:   return K_ERROR;
			endcase
		endfunction

		function void emit(logic [3:0] kind, logic [7:0] cv, logic iend,
				logic [31:0] mant, logic [4:0] frac, logic sat);
			result_t r;
			r.kind = kind;
			r.char_value = cv;
			r.ident_end = iend;
			r.mantissa = mant;
			r.frac_digits = frac;
			r.saturated = sat;
			r.last = 1'b0;
			byte_tokens.push_back(r);
		endfunction

		function void start_from_idle(logic [7:0] c);
			logic [3:0] op;
			op = op_kind(c);
			mode = MD_IDLE;
			if (c == CH_NUL) begin
				emit(K_EOF, 8'h00, 1'b0, 32'd0, 5'd0, 1'b0);
			end else if (is_blank(c)) begin
				// skipped
			end else if (op != K_ERROR) begin
				emit(op, c, 1'b0, 32'd0, 5'd0, 1'b0);
			end else if (is_alpha(c)) begin
				word_buf[0] = c;
				word_len = 1;
				mode = MD_WORD;
			end else if (is_digit(c)) begin
				num_value = 32'(c - CH_0);
				frac_count = '0;
				num_ovf = 1'b0;
				mode = MD_INT;
			end else begin
				emit(K_ERROR, c, 1'b0, 32'd0, 5'd0, 1'b0);
				mode = MD_DRAIN;
			end
		endfunction

		function void accumulate(logic [7:0] c);
			logic [35:0] t;
			t = 36'(num_value) * 36'd10 + 36'(c - CH_0);
			if (t > 36'hFFFF_FFFF) begin
				num_value = '1;
				num_ovf = 1'b1;
			end else begin
				num_value = t[31:0];
			end
		endfunction

		function void flush_word();
			if (word_len == 2 && word_buf[0] == CH_F && word_buf[1] == CH_N) begin
				emit(K_FN, 8'h00, 1'b0, 32'd0, 5'd0, 1'b0);
			end else begin
				for (int i = 0; i < word_len; i++)
					emit(K_IDENT, word_buf[i], i == word_len - 1, 32'd0, 5'd0, 1'b0);
			end
			word_len = 0;
		endfunction

		function void flush_number();
			emit(K_LITERAL, 8'h00, 1'b0, num_value, frac_count, num_ovf);
			num_value = '0;
			frac_count = '0;
			num_ovf = 1'b0;
		endfunction

		// Notes one accepted byte; returns 0 when the byte was dropped while
		// draining after an error.
		function bit note_byte(logic [7:0] c);
			bit      kept;
			result_t r;
			kept = (mode != MD_DRAIN);
			byte_tokens.delete();
			case (mode)
				MD_DRAIN: begin
					if (c == CH_NUL)
						mode = MD_IDLE;
				end
				MD_WORD: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (word_len >= WORD_CAP - 1) begin
							word_len = 0;
							emit(K_ERROR, c, 1'b0, 32'd0, 5'd0, 1'b0);
							mode = MD_DRAIN;
						end else begin
							word_buf[word_len] = c;
							word_len++;
						end
					end else begin
						flush_word();
						start_from_idle(c);
					end
				end
				MD_INT: begin
					if (is_digit(c)) begin
						accumulate(c);
					end else if (c == CH_POINT) begin
						mode = MD_FRAC;
					end else begin
						flush_number();
						start_from_idle(c);
					end
				end
				MD_FRAC: begin
					if (is_digit(c)) begin
						accumulate(c);
						if (frac_count == FRAC_MAX)
							num_ovf = 1'b1;
						else
							frac_count++;
					end else begin
						flush_number();
						start_from_idle(c);
					end
				end
				default: start_from_idle(c);
			endcase
			foreach (byte_tokens[i]) begin
				r = byte_tokens[i];
				r.last = (i == byte_tokens.size() - 1);
				pending_tokens.push_back(r);
			end
			return kept;
		endfunction

		function int outstanding();
			return pending_tokens.size();
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("token %0d: %s expected %0h, got %0h", tokens_checked, field, want, got);
				failures++;
			end
		endfunction

		function void check_token(result_t got);
			result_t want;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token beat: kind %0d char %0h", got.kind, got.char_value);
				failures++;
				return;
			end
			want = pending_tokens.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("char_value", want.char_value, got.char_value);
			compare_field("ident_end", want.ident_end, got.ident_end);
			compare_field("mantissa", want.mantissa, got.mantissa);
			compare_field("frac_digits", want.frac_digits, got.frac_digits);
			compare_field("saturated", want.saturated, got.saturated);
			compare_field("last", want.last, got.last);
			tokens_checked++;
			kind_seen[want.kind]++;
			if (want.kind == K_LITERAL && want.saturated)
				saturated_literals++;
		endfunction
	endclass

endpackage

// ----- test/expression_lexer_unit_tb.sv -----
// Testbench for expression_lexer_unit: drives source bytes, predicts the token
// beats and checks every field of each one, in order.
// Depends on elx_pkg, elx_if, expression_lexer_unit and elx_token_check_pkg.
module expression_lexer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import elx_pkg::*;
	import elx_token_check_pkg::*;

	localparam int WORD_CAP       = 32;
	localparam int ITEM_TARGET    = 420;   // minimum number of source bytes sent
	// Quiet cycles before giving up. The worst legal wait is one receiver
	// or sender stall at 86 % idling; long runs of that kind are vanishingly
	// rare, so this leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;     // extra idle cycles after the last expected token

	localparam logic [7:0] OP_CHARS [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};

	logic clk = 1'b0;
	logic arst_n;

	elx_in_if  text();
	elx_out_if tokens();

	expression_lexer_unit #(
		.WORD_CAP(WORD_CAP)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.tokens (tokens)
	);

	token_scoreboard #(WORD_CAP) lexer_sb;

	int tx_idle_pct;     // chance per cycle that the sender holds valid low
	int rx_idle_pct;     // chance per cycle that the receiver holds ready low
	int scanned_bytes = 0;
	int sent_bytes = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	// Receiver: ready re-rolled every cycle; a beat is taken whenever valid
	// happens to meet it.
	always @(posedge clk)
		tokens.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// Token monitor. Sampling straight after the edge sees the values that
	// the edge acted on, so the check matches the handshake exactly.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && tokens.valid && tokens.ready) begin
			got.kind = tokens.kind;
			got.char_value = tokens.char_value;
			got.ident_end = tokens.ident_end;
			got.mantissa = tokens.mantissa;
			got.frac_digits = tokens.frac_digits;
			got.saturated = tokens.saturated;
			got.last = tokens.last;
			lexer_sb.check_token(got);
		end
	end

	// Watchdog: any beat on either side counts as progress.
	always @(posedge clk) begin
		if ((text.valid && text.ready) || (tokens.valid && tokens.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("expression_lexer_unit test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One source byte. Idle cycles go in front of it at random; valid stays
	// high straight into the next byte when no idle cycle is rolled, so it
	// is never dropped and raised in the same step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid <= 1'b1;
		text.ch <= b;
		@(posedge clk);
		while (!text.ready)
			@(posedge clk);
		sent_bytes++;
		if (lexer_sb.note_byte(b))
			scanned_bytes++;
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		return ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	// Word: mostly short; now and then the keyword, and rarely one just below,
	// at or just past the buffer's capacity (the too-long error).
	task automatic send_word();
		int len;
		if ($urandom_range(0, 7) == 0) begin
			send_byte(CH_F);
			send_byte(CH_N);
			return;
		end
		len = ($urandom_range(0, 24) == 0) ? $urandom_range(WORD_CAP - 3, WORD_CAP + 1)
			: $urandom_range(1, 6);
		send_byte(rand_letter());
		for (int i = 1; i < len; i++)
			send_byte(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
	endtask

	// Literal: integer digits, then maybe a point and fraction digits. Long
	// digit runs saturate the mantissa, very long fractions the digit count;
	// a trailing second point hits the unrecognised-character path.
	task automatic send_literal();
		int int_len;
		int frac_len;
		int pick;
		int_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
		for (int i = 0; i < int_len; i++)
			send_byte(rand_digit());
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return;
		send_byte(CH_POINT);
		frac_len = (pick == 9) ? $urandom_range(30, 34) : $urandom_range(0, 4);
		for (int i = 0; i < frac_len; i++)
			send_byte(rand_digit());
		if (pick == 8)
			send_byte(CH_POINT);
	endtask

	// One expression: a handful of tokens with random content, usually
	// closed by the end byte. A little raw noise keeps every byte value and
	// the error/drain path in play.
	task automatic send_phrase();
		int n;
		int pick;
		n = $urandom_range(1, 10);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 22)
				send_byte(OP_CHARS[$urandom_range(0, 7)]);
			else if (pick < 45)
				send_word();
			else if (pick < 70)
				send_literal();
			else if (pick < 94)
				send_byte(rand_blank());
			else
				send_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 5) != 0)
			send_byte(CH_NUL);
	endtask

	initial begin
		string directed;
		// keyword, all brackets and operators, the letters a and Z, the digit 9,
		// largest mantissa closed right after its point, a tab
		directed = "fn{a9+4294967295.}*(Z)-/\t";

		arst_n = 1'b0;
		text.valid = 1'b0;
		text.ch = CH_NUL;
		tokens.ready = 1'b0;
		tx_idle_pct = 18;
		rx_idle_pct = 86;
		lexer_sb = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed.len(); i++)
			send_byte(directed[i]);
		// top-bit byte is unrecognised; the first end byte only closes the
		// drain, the second gives end of input
		send_byte(8'hFF);
		send_byte(CH_NUL);
		send_byte(CH_NUL);

		// idling: slow receiver first, then slow sender, then flat out
		while (sent_bytes < ITEM_TARGET) begin
			if (sent_bytes >= 2 * ITEM_TARGET / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (sent_bytes >= ITEM_TARGET / 3) begin
				tx_idle_pct = 86;
				rx_idle_pct = 18;
			end
			send_phrase();
		end
		text.valid <= 1'b0;

		while (lexer_sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d source bytes (%0d outside drained input), %0d token beats",
			sent_bytes, scanned_bytes, lexer_sb.tokens_checked);
		$display("ident chars %0d, fn %0d, literals %0d (%0d saturated), errors %0d, eof %0d",
			lexer_sb.kind_seen[K_IDENT], lexer_sb.kind_seen[K_FN],
			lexer_sb.kind_seen[K_LITERAL], lexer_sb.saturated_literals,
			lexer_sb.kind_seen[K_ERROR], lexer_sb.kind_seen[K_EOF]);
		if (lexer_sb.failures == 0)
			$display("expression_lexer_unit test passed");
		else
			$display("expression_lexer_unit test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/elx_pkg.sv
hw/rtl/elx_if.sv
hw/rtl/elx_front.sv
hw/rtl/elx_back.sv
hw/rtl/expression_lexer_unit.sv
hw/rtl/elx_checker.sv
test/elx_token_check_pkg.sv
test/expression_lexer_unit_tb.sv
